// ----- rtl/lsm_pkg.sv -----
// ---------------------------------------------------------------------------
// lsm_pkg: shared types and constants for the line substring matcher
// Byte and count widths, register indexes, item kinds and the cell control word.
// ---------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 5;              // pattern length and line count width
  localparam int PAT_BYTES = 16;             // bytes held by the two pattern registers
  localparam int POS_W     = 4;              // index into the pattern bytes
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] FILL_TOP = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

  typedef struct packed {
    logic             shift;  // a character word is taken this cycle
    logic [LEN_W-1:0] len;    // active pattern length, already clamped
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lsm_cell.sv -----
// ---------------------------------------------------------------------------
// lsm_cell: one window position of the matcher
// Holds one recent byte, passes it on to the next cell on every character and
// compares the incoming byte against the pattern byte that lines up with it.
// ---------------------------------------------------------------------------
`default_nettype none

module lsm_cell #(
  parameter int INDEX = 0
) (
  input  wire                          clk,
  input  wire  lsm_pkg::cell_ctl_t     ctl,
  input  wire  lsm_pkg::pattern_t      pattern,
  input  wire  [lsm_pkg::BYTE_W-1:0]   byte_in,
  output logic [lsm_pkg::BYTE_W-1:0]   byte_out,
  output logic                         hit
);

  localparam logic [lsm_pkg::LEN_W-1:0] POS = lsm_pkg::LEN_W'(INDEX);

  logic [lsm_pkg::LEN_W-1:0] pos_full;
  logic [lsm_pkg::POS_W-1:0] pos;
  logic                      in_use;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_out <= byte_in;
    end
  end

  // pattern byte len-1-INDEX sits INDEX places back from the newest byte
  assign pos_full = ctl.len - POS - lsm_pkg::LEN_W'(1);
  assign pos      = pos_full[lsm_pkg::POS_W-1:0];
  assign in_use   = (POS < ctl.len);
  assign hit      = !in_use || (byte_in == pattern[pos]);

endmodule

`default_nettype wire

// ----- rtl/line_substring_matcher.sv -----
// ---------------------------------------------------------------------------
// line_substring_matcher: fixed-string line filter
// Reports for each text line whether it holds the configured pattern.
// ---------------------------------------------------------------------------
// Usage:
//   Input words carry kind and character; a word is taken when in_valid is
//   high and in_stall is low. A character word produces no result; an
//   end-of-line word produces one result word on the output channel,
//   line_matches, in the cycle after it is taken.
//   One word per cycle is taken back to back while in_stall is low: the
//   window is a row of PATTERN_MAX cells that shift and compare in parallel,
//   so the rate is set by a single compare-and-AND path per character.
//   The result sits in an output register; in_stall rises only while that
//   register is full and out_stall holds it, so input stops for as long as
//   the receiver stalls with a result pending. Pattern registers are written
//   through cfg_write, cfg_index, cfg_data while the block is idle; the user
//   must ensure it, the block does not. Reset clears the registers, line
//   count, match flag and output valid; the block takes words the next cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module line_substring_matcher #(
  parameter int PATTERN_MAX = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire  [lsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [lsm_pkg::CFG_W-1:0]        cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              kind,
  input  wire  [lsm_pkg::BYTE_W-1:0]       character,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             line_matches
);

  logic [lsm_pkg::CFG_W-1:0] pattern_low;
  logic [lsm_pkg::CFG_W-1:0] pattern_high;
  logic [lsm_pkg::LEN_W-1:0] pattern_length;

  logic [lsm_pkg::LEN_W-1:0] line_fill;
  logic [lsm_pkg::LEN_W-1:0] line_fill_next;
  logic                      found_flag;

  lsm_pkg::pattern_t         pattern;
  lsm_pkg::cell_ctl_t        ctl;
  logic [lsm_pkg::LEN_W-1:0] len;
  logic                      in_take;
  logic                      window_hit;

  logic [PATTERN_MAX:0][lsm_pkg::BYTE_W-1:0] chain;
  logic [PATTERN_MAX-1:0]                    hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lsm_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        lsm_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        lsm_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[lsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern = {pattern_high, pattern_low};
  assign len = (pattern_length > lsm_pkg::LEN_W'(PATTERN_MAX)) ?
               lsm_pkg::LEN_W'(PATTERN_MAX) : pattern_length;

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign ctl.shift = in_take && (kind == lsm_pkg::KIND_CHAR);
  assign ctl.len   = len;

  assign chain[0] = character;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    lsm_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pattern  (pattern),
      .byte_in  (chain[i]),
      .byte_out (chain[i+1]),
      .hit      (hits[i])
    );
  end

  assign line_fill_next = (line_fill == lsm_pkg::FILL_TOP) ? line_fill :
                          line_fill + lsm_pkg::LEN_W'(1);
  // an empty pattern passes here too: every cell is idle and the count test holds
  assign window_hit = (&hits) && (line_fill_next >= len);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill  <= '0;
      found_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        if (kind == lsm_pkg::KIND_EOL) begin
          line_fill    <= '0;
          found_flag   <= 1'b0;
          out_valid    <= 1'b1;
          line_matches <= found_flag || (len == '0);
        end else begin
          line_fill <= line_fill_next;
          if (window_hit) begin
            found_flag <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
